### rtl/kce_pkg.sv
// ----------------------------------------------------------------------------
// kce_pkg
// Shared types and constants of the Kirsch compass edge filter.
// ----------------------------------------------------------------------------
package kce_pkg;

    localparam int MAX_LINE_PIXELS_DEF = 2048;

    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int COL_OUT_W  = 11;
    localparam int ROW_W      = 12;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [HEIGHT_W-1:0] ROW_LIMIT  = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_kce_reg;

    typedef struct packed {
        logic [PIX_W-1:0] gray_in;
        logic             frame_start;
    } t_kce_in;

    typedef struct packed {
        logic [PIX_W-1:0]     edge_level;
        logic [COL_OUT_W-1:0] center_col;
        logic [ROW_W-1:0]     center_row;
        logic                 frame_end;
    } t_kce_out;

    // position tags that travel beside the window through the arithmetic
    typedef struct packed {
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 frame_end;
    } t_kce_tag;

    // compass ring, clockwise from the upper-left neighbour
    typedef logic [7:0][PIX_W-1:0] t_kce_ring;

endpackage

### rtl/kce_kirsch.sv
// ----------------------------------------------------------------------------
// kce_kirsch
// Pipelined Kirsch compass evaluation: ring sums, eight clamped responses,
// maximum, and a registered result transaction.
// ----------------------------------------------------------------------------
module kce_kirsch (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  kce_pkg::t_kce_ring i_ring,
    input  kce_pkg::t_kce_tag  i_tag,
    output logic              o_valid,
    input  logic              i_ready,
    output kce_pkg::t_kce_out o_data
);

    // stage a: ring
    logic               r_a_v;
    kce_pkg::t_kce_ring r_a_ring;
    kce_pkg::t_kce_tag  r_a_tag;
    // stage b: sums
    logic               r_b_v;
    logic [12:0]        r_b_t3;
    logic [7:0][9:0]    r_b_s3;
    kce_pkg::t_kce_tag  r_b_tag;
    // stage c: clamped responses
    logic               r_c_v;
    logic [7:0][7:0]    r_c_resp;
    kce_pkg::t_kce_tag  r_c_tag;
    // result
    logic               r_o_v;
    kce_pkg::t_kce_out  r_o_data;

    logic rdy_o, rdy_c, rdy_b;

    logic [10:0]     n_total;
    logic [12:0]     n_t3;
    logic [7:0][9:0] n_s3;
    logic [7:0][7:0] n_resp;
    logic [3:0][7:0] max_l1;
    logic [1:0][7:0] max_l2;
    logic [7:0]      n_max;

    assign rdy_o   = !r_o_v || i_ready;
    assign rdy_c   = !r_c_v || rdy_o;
    assign rdy_b   = !r_b_v || rdy_c;
    assign o_ready = !r_a_v || rdy_b;

    always_comb begin
        n_total = '0;
        for (int m = 0; m < 8; m++) begin
            n_total = n_total + 11'(r_a_ring[m]);
        end
        n_t3 = 13'({n_total, 1'b0}) + 13'(n_total);
        for (int m = 0; m < 8; m++) begin
            n_s3[m] = 10'(r_a_ring[m]) + 10'(r_a_ring[(m + 1) & 7])
                    + 10'(r_a_ring[(m + 2) & 7]);
        end
    end

    always_comb begin
        logic signed [13:0] diff;
        diff = '0;
        for (int m = 0; m < 8; m++) begin
            diff = $signed({1'b0, r_b_s3[m], 3'b000}) - $signed({1'b0, r_b_t3});
            if (diff < 0) begin
                n_resp[m] = 8'd0;
            end else if (diff > 14'sd255) begin
                n_resp[m] = 8'd255;
            end else begin
                n_resp[m] = diff[7:0];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            max_l1[k] = (r_c_resp[2*k] > r_c_resp[2*k+1]) ? r_c_resp[2*k] : r_c_resp[2*k+1];
        end
        for (int k = 0; k < 2; k++) begin
            max_l2[k] = (max_l1[2*k] > max_l1[2*k+1]) ? max_l1[2*k] : max_l1[2*k+1];
        end
        n_max = (max_l2[0] > max_l2[1]) ? max_l2[0] : max_l2[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_v <= i_valid;
            end
            if (rdy_b) begin
                r_b_v <= r_a_v;
            end
            if (rdy_c) begin
                r_c_v <= r_b_v;
            end
            if (rdy_o) begin
                r_o_v <= r_c_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_a_ring <= i_ring;
            r_a_tag  <= i_tag;
        end
        if (rdy_b) begin
            r_b_t3  <= n_t3;
            r_b_s3  <= n_s3;
            r_b_tag <= r_a_tag;
        end
        if (rdy_c) begin
            r_c_resp <= n_resp;
            r_c_tag  <= r_b_tag;
        end
        if (rdy_o) begin
            r_o_data.edge_level <= n_max;
            r_o_data.center_col <= r_c_tag.col;
            r_o_data.center_row <= r_c_tag.row;
            r_o_data.frame_end  <= r_c_tag.frame_end;
        end
    end

    assign o_valid = r_o_v;
    assign o_data  = r_o_data;

endmodule

### rtl/kirsch_compass_edge_filter_top.sv
// ----------------------------------------------------------------------------
// kirsch_compass_edge_filter_top
// 3x3 Kirsch compass edge filter on a raster stream of grey pixels, with two
// line stores in block memory and a pipelined compass evaluation.
//
//   channel   direction  handshake                payload
//   pixel     in         i_in_valid / o_in_ready  i_in_data (t_kce_in)
//   result    out        o_out_valid/ i_out_ready o_out_data (t_kce_out)
//   config    in         i_cfg_we                 i_cfg_idx, i_cfg_wdata
//
// one pixel transaction per cycle while o_in_ready is high; a result is registered in the
// line store stage, stages a, b, c and the result register; line stores are read at accept,
// written back as the pixel leaves that stage, bypassed for a same-column read in that cycle
// border pixels leave the pipeline after the line store stage
// reset clears counters, window and valids; line stores are not cleared
// a stalled result holds the stages behind it, the empty ones keep filling
// ----------------------------------------------------------------------------
module kirsch_compass_edge_filter_top #(
    parameter int MAX_LINE_PIXELS = kce_pkg::MAX_LINE_PIXELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  kce_pkg::t_kce_in                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output kce_pkg::t_kce_out               o_out_data,
    input  logic                            i_cfg_we,
    input  logic [kce_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kce_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int CW = $clog2(MAX_LINE_PIXELS);
    localparam int EW = CW + 1;

    logic [kce_pkg::WIDTH_W-1:0]  r_width;
    logic [kce_pkg::HEIGHT_W-1:0] r_height;

    logic [CW-1:0]             r_col, n_col;
    logic [kce_pkg::ROW_W-1:0] r_row, n_row;

    logic [EW-1:0]                ew;
    logic [kce_pkg::HEIGHT_W-1:0] eh;

    logic [CW-1:0]             col_base, cur_col;
    logic [kce_pkg::ROW_W-1:0] row_base, cur_row;
    logic [EW-1:0]             col_inc;
    logic [kce_pkg::HEIGHT_W-1:0] row_inc;
    logic [CW-1:0]             col_m1;
    logic                      produce, last_pix;
    logic                      acc;

    // line stores
    logic [7:0] r_line_upper  [MAX_LINE_PIXELS];
    logic [7:0] r_line_middle [MAX_LINE_PIXELS];
    logic [7:0] r_rd_upper, r_rd_middle;

    logic       r_fwd;
    logic [7:0] r_fwd_top, r_fwd_mid;

    // line store stage
    logic              r_s1_v;
    logic              r_s1_prod;
    logic [7:0]        r_s1_pix;
    logic [CW-1:0]     r_s1_addr;
    kce_pkg::t_kce_tag r_s1_tag;
    logic              s1_fire;
    logic [7:0]        s1_top, s1_mid;

    logic [5:0][7:0]    r_win;
    kce_pkg::t_kce_ring ring;
    logic               kk_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= kce_pkg::WIDTH_RST;
            r_height <= kce_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (kce_pkg::t_kce_reg'(i_cfg_idx))
                kce_pkg::REG_FRAME_WIDTH: begin
                    r_width <= i_cfg_wdata[kce_pkg::WIDTH_W-1:0];
                end
                kce_pkg::REG_FRAME_HEIGHT: begin
                    r_height <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // effective frame size
    always_comb begin
        if ({20'd0, r_width} > 32'(MAX_LINE_PIXELS)) begin
            ew = EW'(MAX_LINE_PIXELS);
        end else if (r_width == '0) begin
            ew = EW'(1);
        end else begin
            ew = EW'(r_width);
        end
        if (r_height > kce_pkg::ROW_LIMIT) begin
            eh = kce_pkg::ROW_LIMIT;
        end else if (r_height == '0) begin
            eh = 13'd1;
        end else begin
            eh = r_height;
        end
    end

    // position of the arriving pixel and of the one after it
    always_comb begin
        col_base = i_in_data.frame_start ? '0 : r_col;
        row_base = i_in_data.frame_start ? '0 : r_row;
        cur_col  = ({1'b0, col_base} >= ew) ? '0 : col_base;
        cur_row  = ({1'b0, row_base} >= eh) ? '0 : row_base;
        col_inc  = {1'b0, cur_col} + EW'(1);
        row_inc  = {1'b0, cur_row} + 13'd1;
        if (col_inc >= ew) begin
            n_col = '0;
            n_row = (row_inc >= eh) ? '0 : row_inc[kce_pkg::ROW_W-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = cur_row;
        end
        col_m1   = cur_col - CW'(1);
        produce  = (cur_col >= CW'(2)) && (cur_row >= 12'd2);
        last_pix = ({1'b0, cur_col} == ew - EW'(1)) && ({1'b0, cur_row} == eh - 13'd1);
    end

    assign acc        = i_in_valid && o_in_ready;
    assign s1_fire    = r_s1_v && (!r_s1_prod || kk_ready);
    assign o_in_ready = !r_s1_v || s1_fire;

    assign s1_top = r_fwd ? r_fwd_top : r_rd_upper;
    assign s1_mid = r_fwd ? r_fwd_mid : r_rd_middle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
            r_fwd  <= 1'b0;
        end else begin
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
                r_fwd <= s1_fire && (r_s1_addr == cur_col);
            end
            if (o_in_ready) begin
                r_s1_v <= acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix           <= i_in_data.gray_in;
            r_s1_addr          <= cur_col;
            r_s1_prod          <= produce;
            r_s1_tag.col       <= kce_pkg::COL_OUT_W'(col_m1);
            r_s1_tag.row       <= cur_row - 12'd1;
            r_s1_tag.frame_end <= last_pix;
            r_fwd_top          <= s1_mid;
            r_fwd_mid          <= r_s1_pix;
        end
    end

    // line store read at accept, write back as the pixel leaves the stage
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_upper  <= r_line_upper[cur_col];
            r_rd_middle <= r_line_middle[cur_col];
        end
        if (s1_fire) begin
            r_line_upper[r_s1_addr]  <= s1_mid;
            r_line_middle[r_s1_addr] <= r_s1_pix;
        end
    end

    // window: [0..2] oldest column, [3..5] middle column, top to bottom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_fire) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= s1_top;
            r_win[4] <= s1_mid;
            r_win[5] <= r_s1_pix;
        end
    end

    always_comb begin
        ring[0] = r_win[0];
        ring[1] = r_win[3];
        ring[2] = s1_top;
        ring[3] = s1_mid;
        ring[4] = r_s1_pix;
        ring[5] = r_win[5];
        ring[6] = r_win[2];
        ring[7] = r_win[1];
    end

    kce_kirsch u_kirsch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_v && r_s1_prod),
        .o_ready (kk_ready),
        .i_ring  (ring),
        .i_tag   (r_s1_tag),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // bypass only ever stands in for the entry that was just written
    a_fwd_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && r_fwd |-> r_s1_addr == $past(r_s1_addr))
        else $error("line store bypass on a different column");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !s1_fire |=> r_s1_v && $stable(r_s1_addr) && $stable(r_s1_pix))
        else $error("stalled line store stage lost its pixel");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> {1'b0, r_col} < $past(ew))
        else $error("column counter beyond frame width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> {1'b0, r_row} < $past(eh))
        else $error("row counter beyond frame height");

endmodule
